FILE: rtl/hfn_pkg.sv
// Shared types and constants of the height-field normal kernel.
package hfn_pkg;

    localparam int HFN_MAX_GRID = 1024;
    localparam int GRID_W       = 11;
    localparam int H_W          = 16;
    localparam int MAG_W        = 16;
    localparam int SQ_W         = 32;
    localparam int SUM_W        = 34;
    localparam int Q_W          = 15;

    localparam logic [GRID_W-1:0] GRID_RESET = 11'd256;
    localparam logic [Q_W-1:0]    Q_UNIT     = 15'd16384;
    // 1.0 in Q8.8, squared
    localparam logic [SQ_W-1:0]   ONE_SQ     = 32'h0001_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_UP,
        S_RD_LEFT,
        S_RD_RIGHT,
        S_DIFF,
        S_SQ_X,
        S_SQ_Z,
        S_SUM,
        S_START,
        S_WAIT,
        S_EDGE_WR,
        S_OUT1,
        S_OUT2
    } t_state;

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_DIV,
        DS_SQRT,
        DS_DONE
    } t_ds_state;

    typedef enum logic [1:0] {
        C_X,
        C_Y,
        C_Z
    } t_comp;

    typedef struct packed {
        logic             start;
        logic [SQ_W-1:0]  mag2;
        logic [SUM_W-1:0] sum;
    } t_ds_req;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] mag;
    } t_ds_rsp;

endpackage

FILE: rtl/hfn_if.sv
// Valid/ready channel interfaces for height samples and normals.
interface hfn_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] height_sample;

    modport source (output valid, output height_sample, input ready);
    modport sink   (input valid, input height_sample, output ready);
endinterface

interface hfn_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] normal_x;
    logic [14:0]        normal_y;
    logic signed [15:0] normal_z;
    logic [9:0]         out_row;
    logic [9:0]         out_col;
    logic               last_of_grid;

    modport source (output valid, output normal_x, output normal_y, output normal_z,
                    output out_row, output out_col, output last_of_grid, input ready);
    modport sink   (input valid, input normal_x, input normal_y, input normal_z,
                    input out_row, input out_col, input last_of_grid, output ready);
endinterface

FILE: rtl/hfn_divsqrt.sv
// Shared iterative unit: restoring divide then bit-serial square root, rounded half.
module hfn_divsqrt import hfn_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_ds_req i_req,
    output t_ds_rsp o_rsp
);

    t_ds_state        r_state, n_state;
    logic [SUM_W-1:0] r_rem,   n_rem;
    logic [SUM_W-1:0] r_sum,   n_sum;
    logic [30:0]      r_dbits, n_dbits;
    logic [30:0]      r_quo,   n_quo;
    logic [4:0]       r_cnt,   n_cnt;
    logic [15:0]      r_root,  n_root;
    logic [16:0]      r_srem,  n_srem;
    logic [31:0]      r_rad,   n_rad;

    logic [SUM_W:0]   w_dsh;
    logic             w_dge;
    logic [SUM_W:0]   w_dsub;
    logic [18:0]      w_sacc;
    logic [18:0]      w_trial;
    logic             w_sge;
    logic [18:0]      w_ssub;
    logic [16:0]      w_round;

    always_comb begin
        w_dsh   = {r_rem, r_dbits[30]};
        w_dge   = w_dsh >= {1'b0, r_sum};
        w_dsub  = w_dsh - {1'b0, r_sum};
        w_sacc  = {r_srem, r_rad[31:30]};
        w_trial = {1'b0, r_root, 2'b01};
        w_sge   = w_sacc >= w_trial;
        w_ssub  = w_sacc - w_trial;
        w_round = {1'b0, r_root} + 17'd1;
    end

    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        n_sum   = r_sum;
        n_dbits = r_dbits;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_root  = r_root;
        n_srem  = r_srem;
        n_rad   = r_rad;
        unique case (r_state)
            DS_IDLE: begin
                if (i_req.start) begin
                    // dividend is mag2 << 30; top bits seed the remainder
                    n_rem   = {3'b000, i_req.mag2[SQ_W-1:1]};
                    n_dbits = {i_req.mag2[0], 30'd0};
                    n_sum   = i_req.sum;
                    n_quo   = '0;
                    n_cnt   = 5'd30;
                    n_state = DS_DIV;
                end
            end
            DS_DIV: begin
                n_rem   = w_dge ? w_dsub[SUM_W-1:0] : w_dsh[SUM_W-1:0];
                n_quo   = {r_quo[29:0], w_dge};
                n_dbits = {r_dbits[29:0], 1'b0};
                n_cnt   = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_rad   = {1'b0, n_quo};
                    n_srem  = '0;
                    n_root  = '0;
                    n_cnt   = 5'd15;
                    n_state = DS_SQRT;
                end
            end
            DS_SQRT: begin
                n_srem = w_sge ? w_ssub[16:0] : w_sacc[16:0];
                n_root = {r_root[14:0], w_sge};
                n_rad  = {r_rad[29:0], 2'b00};
                n_cnt  = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_state = DS_DONE;
                end
            end
            DS_DONE: begin
                n_state = DS_IDLE;
            end
            default: begin
                n_state = DS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_sum   <= n_sum;
        r_dbits <= n_dbits;
        r_quo   <= n_quo;
        r_cnt   <= n_cnt;
        r_root  <= n_root;
        r_srem  <= n_srem;
        r_rad   <= n_rad;
    end

    // root is the largest m with m*m <= q; result is (root + 1) / 2
    assign o_rsp.done = (r_state == DS_DONE);
    assign o_rsp.mag  = w_round[Q_W:1];

endmodule

FILE: rtl/heightfield_normal_kernel.sv
// Top level: line store, grid counters and the sequencer around the divide/root unit.
//
//  channel   dir  signals                                   transfer when
//  i_in      in   valid, ready, height_sample               valid & ready
//  o_out     out  valid, ready, normal_x/y/z, row, col, last valid & ready
//  cfg       in   i_cfg_wr_en, i_cfg_wr_data (grid_size)     i_cfg_wr_en
//
// Interior point: reads, differences and squares, then three passes through the shared
// divide/root unit (31 divide steps and 16 root steps per component, three components).
// Edge point or first-row sample: no divide/root pass; first-row samples give no result.
// One sample at a time; i_in.ready is high only while idle.
// A stalled result holds on o_out until taken. Synchronous active-low reset
// sets grid_size to 256 and clears the counters; the line store is not cleared.
module heightfield_normal_kernel import hfn_pkg::*; #(
    parameter int MAX_GRID = HFN_MAX_GRID
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hfn_in_if.sink            i_in,
    hfn_out_if.source         o_out,
    input  logic              i_cfg_wr_en,
    input  logic [GRID_W-1:0] i_cfg_wr_data
);

    localparam int CW    = $clog2(MAX_GRID);
    localparam int NW    = $clog2(MAX_GRID + 1);
    localparam int EW    = (NW > GRID_W) ? NW : GRID_W;
    localparam int AW    = $clog2(2 * MAX_GRID);
    localparam int XW    = (CW > 10) ? CW : 10;
    localparam int DEPTH = 2 * MAX_GRID;

    t_state            r_state, n_state;
    t_comp             r_comp,  n_comp;
    logic [GRID_W-1:0] r_grid;
    logic [CW-1:0]     r_row, r_col;
    logic [CW-1:0]     r_cur_row, r_cur_col;
    logic              r_first, r_second, r_last_pt;
    logic [H_W-1:0]    r_h;

    logic [H_W-1:0]    r_mem [DEPTH];
    logic [H_W-1:0]    r_rdata;
    logic [H_W-1:0]    r_up, r_left;
    logic signed [16:0] r_dx, r_dz;
    logic [SQ_W-1:0]   r_sqx, r_sqz;
    logic [SUM_W-1:0]  r_sum;
    logic [15:0]       r_nx, r_nz;
    logic [Q_W-1:0]    r_ny;

    logic [EW-1:0]     w_grid_ext, w_n_ext;
    logic [NW-1:0]     w_n, w_col_ext, w_row_ext;
    logic              w_col_last, w_row_last, w_inner;
    logic              w_accept;
    logic [AW-1:0]     w_cur_base, w_prev_base, w_wa, w_ra;
    logic              w_we;
    logic [16:0]       w_dx, w_dz;
    logic [MAG_W-1:0]  w_magx, w_magz, w_mul_a;
    logic [SQ_W-1:0]   w_prod;
    t_ds_req           w_req;
    t_ds_rsp           w_rsp;
    logic              w_neg;
    logic [15:0]       w_signed;
    logic [CW-1:0]     w_pr;
    logic [XW-1:0]     w_row_x, w_col_x;

    // effective grid size, clamped to [2, MAX_GRID]
    always_comb begin
        w_grid_ext = EW'(r_grid);
        if (w_grid_ext < EW'(2)) begin
            w_n_ext = EW'(2);
        end else if (w_grid_ext > EW'(MAX_GRID)) begin
            w_n_ext = EW'(MAX_GRID);
        end else begin
            w_n_ext = w_grid_ext;
        end
        w_n        = w_n_ext[NW-1:0];
        w_col_ext  = NW'(r_col);
        w_row_ext  = NW'(r_row);
        w_col_last = (NW'(w_col_ext + NW'(1)) == w_n);
        w_row_last = (NW'(w_row_ext + NW'(1)) == w_n);
        w_inner    = (r_row >= CW'(2)) && (r_col != '0)
                     && ((NW+1)'(w_col_ext) + (NW+1)'(2) <= (NW+1)'(w_n));
        w_accept   = i_in.valid && i_in.ready;
    end

    // line store addressing: row parity picks the half
    always_comb begin
        w_cur_base  = r_cur_row[0] ? AW'(MAX_GRID) : '0;
        w_prev_base = r_cur_row[0] ? '0 : AW'(MAX_GRID);
        w_wa        = w_cur_base + AW'(r_cur_col);
        w_we        = (r_state == S_DIFF) || (r_state == S_EDGE_WR);
        case (r_state)
            S_RD_LEFT:  w_ra = w_prev_base + AW'(r_cur_col) - AW'(1);
            S_RD_RIGHT: w_ra = w_prev_base + AW'(r_cur_col) + AW'(1);
            default:    w_ra = w_wa;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= r_h;
        end
        r_rdata <= r_mem[w_ra];
    end

    // differences and the shared squarer
    always_comb begin
        w_dx    = {r_up[15], r_up} - {r_h[15], r_h};
        w_dz    = {r_left[15], r_left} - {r_rdata[15], r_rdata};
        w_magx  = r_dx[16] ? MAG_W'(-r_dx) : MAG_W'(r_dx);
        w_magz  = r_dz[16] ? MAG_W'(-r_dz) : MAG_W'(r_dz);
        w_mul_a = (r_state == S_SQ_X) ? w_magx : w_magz;
        w_prod  = w_mul_a * w_mul_a;
    end

    always_comb begin
        w_req.start = (r_state == S_START);
        w_req.sum   = r_sum;
        case (r_comp)
            C_X:     w_req.mag2 = r_sqx;
            C_Z:     w_req.mag2 = r_sqz;
            default: w_req.mag2 = ONE_SQ;
        endcase
        case (r_comp)
            C_X:     w_neg = r_dx[16];
            C_Z:     w_neg = r_dz[16];
            default: w_neg = 1'b0;
        endcase
        w_signed = w_neg ? 16'(-{1'b0, w_rsp.mag}) : {1'b0, w_rsp.mag};
    end

    hfn_divsqrt u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        n_comp  = r_comp;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_inner ? S_RD_UP : S_EDGE_WR;
                end
            end
            S_RD_UP:    n_state = S_RD_LEFT;
            S_RD_LEFT:  n_state = S_RD_RIGHT;
            S_RD_RIGHT: n_state = S_DIFF;
            S_DIFF:     n_state = S_SQ_X;
            S_SQ_X:     n_state = S_SQ_Z;
            S_SQ_Z:     n_state = S_SUM;
            S_SUM: begin
                n_comp  = C_X;
                n_state = S_START;
            end
            S_START:    n_state = S_WAIT;
            S_WAIT: begin
                if (w_rsp.done) begin
                    unique case (r_comp)
                        C_X: begin
                            n_comp  = C_Y;
                            n_state = S_START;
                        end
                        C_Y: begin
                            n_comp  = C_Z;
                            n_state = S_START;
                        end
                        default: n_state = S_OUT1;
                    endcase
                end
            end
            S_EDGE_WR: begin
                if (r_first) begin
                    n_state = S_OUT1;
                end else if (r_second) begin
                    n_state = S_OUT2;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT1: begin
                if (o_out.ready) begin
                    n_state = r_second ? S_OUT2 : S_IDLE;
                end
            end
            S_OUT2: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_comp  <= C_X;
            r_grid  <= GRID_RESET;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_comp  <= n_comp;
            if (i_cfg_wr_en) begin
                r_grid <= i_cfg_wr_data;
                r_row  <= '0;
                r_col  <= '0;
            end else if (w_accept) begin
                if (w_col_last) begin
                    r_col <= '0;
                    r_row <= w_row_last ? '0 : CW'(r_row + CW'(1));
                end else begin
                    r_col <= CW'(r_col + CW'(1));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_h       <= i_in.height_sample;
            r_cur_row <= r_row;
            r_cur_col <= r_col;
            r_first   <= (r_row != '0);
            r_second  <= w_row_last;
            r_last_pt <= w_row_last && w_col_last;
        end
        if (r_state == S_RD_LEFT) begin
            r_up <= r_rdata;
        end
        if (r_state == S_RD_RIGHT) begin
            r_left <= r_rdata;
        end
        if (r_state == S_DIFF) begin
            r_dx <= w_dx;
            r_dz <= w_dz;
        end
        if (r_state == S_SQ_X) begin
            r_sqx <= w_prod;
        end
        if (r_state == S_SQ_Z) begin
            r_sqz <= w_prod;
        end
        if (r_state == S_SUM) begin
            r_sum <= SUM_W'(r_sqx) + SUM_W'(r_sqz) + SUM_W'(ONE_SQ);
        end
        if (r_state == S_EDGE_WR) begin
            r_nx <= '0;
            r_ny <= Q_UNIT;
            r_nz <= '0;
        end
        if (r_state == S_WAIT && w_rsp.done) begin
            case (r_comp)
                C_X:     r_nx <= w_signed;
                C_Y:     r_ny <= w_rsp.mag;
                default: r_nz <= w_signed;
            endcase
        end
    end

    // outputs: second result of a last-row sample is its own edge normal
    always_comb begin
        w_pr    = CW'(r_cur_row - CW'(1));
        w_row_x = (r_state == S_OUT2) ? XW'(r_cur_row) : XW'(w_pr);
        w_col_x = XW'(r_cur_col);
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = (r_state == S_OUT1) || (r_state == S_OUT2);
    assign o_out.normal_x      = (r_state == S_OUT2) ? '0 : r_nx;
    assign o_out.normal_y      = (r_state == S_OUT2) ? Q_UNIT : r_ny;
    assign o_out.normal_z      = (r_state == S_OUT2) ? '0 : r_nz;
    assign o_out.out_row       = w_row_x[9:0];
    assign o_out.out_col       = w_col_x[9:0];
    assign o_out.last_of_grid  = (r_state == S_OUT2) && r_last_pt;

endmodule

FILE: rtl/hfn_chk.sv
// Port-level assertions for the height-field normal kernel, bound to the top.
module hfn_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_x,
    input logic [14:0] out_y,
    input logic [15:0] out_z,
    input logic        out_last
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // never takes a sample while a result is pending
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ready && out_valid))
        else $error("input ready while result pending");

    // after a sample transfer the block is not ready in the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after a transfer");

    // final point lies on the edge
    a_last_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_last |-> out_y == 15'd16384 && out_x == 16'd0 && out_z == 16'd0)
        else $error("last point normal not flat");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !out_valid)
        else $error("result valid after reset");

endmodule

bind heightfield_normal_kernel hfn_chk u_hfn_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_in.valid),
    .in_ready  (i_in.ready),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_x     (o_out.normal_x),
    .out_y     (o_out.normal_y),
    .out_z     (o_out.normal_z),
    .out_last  (o_out.last_of_grid)
);
